@@ sv/crfd_pkg.sv @@
// Package for the compact record field decoder.
// Holds the decoder phase and result kind codes, the state and result structs,
// and the fixed widths. Has no dependencies.
package crfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned LEFT_W    = 6;
  localparam int unsigned ILEN_W    = 5;
  localparam int unsigned INT_BYTES = 4;

  localparam logic [LEFT_W-1:0] STR_LEN_MASK = 6'h3F;
  localparam logic [ILEN_W-1:0] INT_LEN_MASK = 5'h1F;

  typedef enum logic [1:0] {
    PH_COUNT  = 2'd0,
    PH_HEADER = 2'd1,
    PH_STRING = 2'd2,
    PH_INT    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_COUNT = 3'd0,
    KIND_UINT  = 3'd1,
    KIND_SINT  = 3'd2,
    KIND_SBYTE = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_t;

  typedef struct packed {
    phase_t              phase;
    logic [COUNT_W-1:0]  structs_left;
    logic [LEFT_W-1:0]   bytes_left;
    logic [VALUE_W-1:0]  gathered_value;
    logic [ILEN_W-1:0]   int_length;
    logic                field_signed;
    logic                field_is_last;
  } crfd_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic                field_done;
    logic                struct_done;
    logic                record_done;
  } crfd_result_t;

endpackage

@@ sv/crfd_step.sv @@
// Combinational decode of one stream byte against the current decoder state.
// Produces the next state and at most one result word. Depends on crfd_pkg.
module crfd_step import crfd_pkg::*; (
  input  crfd_state_t         state,
  input  logic [BYTE_W-1:0]   stream_byte,
  output crfd_state_t         state_next,
  output logic                res_valid,
  output crfd_result_t        res
);

  logic [VALUE_W-1:0] shifted;
  logic [VALUE_W-1:0] int_value;
  logic [LEFT_W-1:0]  left_dec;
  logic               fdone;
  logic               is_last;

  assign shifted  = {state.gathered_value[VALUE_W-BYTE_W-1:0], stream_byte};
  assign left_dec = state.bytes_left - LEFT_W'(1);

  always_comb begin
    int_value = shifted;
    if (state.field_signed && (32'(state.int_length) <= INT_BYTES)) begin
      case (state.int_length)
        5'd1: int_value = {{24{shifted[7]}}, shifted[7:0]};
        5'd2: int_value = {{16{shifted[15]}}, shifted[15:0]};
        5'd3: int_value = {{8{shifted[23]}}, shifted[23:0]};
        default: int_value = shifted;
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    res_valid       = 1'b0;
    res.kind        = KIND_COUNT;
    res.value       = '0;
    res.field_done  = 1'b0;
    res.struct_done = 1'b0;
    res.record_done = 1'b0;
    fdone           = 1'b0;
    is_last         = state.field_is_last;
    unique case (state.phase)
      PH_COUNT: begin
        state_next.structs_left  = stream_byte;
        state_next.field_is_last = 1'b0;
        res_valid       = 1'b1;
        res.kind        = KIND_COUNT;
        res.value       = VALUE_W'(stream_byte);
        res.record_done = (stream_byte == '0);
        state_next.phase = (stream_byte == '0) ? PH_COUNT : PH_HEADER;
      end
      PH_HEADER: begin
        is_last = stream_byte[7];
        state_next.field_is_last = stream_byte[7];
        if (stream_byte[6]) begin
          state_next.bytes_left   = stream_byte[LEFT_W-1:0] & STR_LEN_MASK;
          state_next.field_signed = 1'b0;
          if ((stream_byte[LEFT_W-1:0] & STR_LEN_MASK) == '0) begin
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
            fdone     = 1'b1;
          end else begin
            state_next.phase = PH_STRING;
          end
        end else begin
          state_next.field_signed   = stream_byte[5];
          state_next.int_length     = stream_byte[ILEN_W-1:0] & INT_LEN_MASK;
          state_next.bytes_left     = LEFT_W'(stream_byte[ILEN_W-1:0] & INT_LEN_MASK);
          state_next.gathered_value = '0;
          if ((stream_byte[ILEN_W-1:0] & INT_LEN_MASK) == '0) begin
            res_valid = 1'b1;
            res.kind  = stream_byte[5] ? KIND_SINT : KIND_UINT;
            fdone     = 1'b1;
          end else begin
            state_next.phase = PH_INT;
          end
        end
      end
      PH_STRING: begin
        state_next.bytes_left = left_dec;
        res_valid = 1'b1;
        res.kind  = KIND_SBYTE;
        res.value = VALUE_W'(stream_byte);
        fdone     = (left_dec == '0);
      end
      PH_INT: begin
        state_next.gathered_value = shifted;
        state_next.bytes_left     = left_dec;
        if (left_dec == '0) begin
          res_valid = 1'b1;
          res.kind  = state.field_signed ? KIND_SINT : KIND_UINT;
          res.value = int_value;
          fdone     = 1'b1;
        end
      end
      default: begin
        state_next.phase = PH_COUNT;
      end
    endcase

    // A completed field moves on to the next header, the next struct, or a new record.
    if (fdone) begin
      res.field_done   = 1'b1;
      state_next.phase = PH_HEADER;
      if (is_last) begin
        res.struct_done = 1'b1;
        if (state.structs_left <= COUNT_W'(1)) begin
          res.record_done         = 1'b1;
          state_next.structs_left = '0;
          state_next.phase        = PH_COUNT;
        end else begin
          state_next.structs_left = state.structs_left - COUNT_W'(1);
        end
      end
    end
  end

endmodule

@@ sv/crfd_out_buf.sv @@
// Two-entry output buffer that holds result words until the consumer takes them.
// Its full flag comes from registers only. Depends on crfd_pkg.
module crfd_out_buf import crfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  crfd_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output crfd_result_t out_data
);

  crfd_result_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic [1:0]   count_next;
  logic         pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ sv/compact_record_field_decoder.sv @@
// Top level of the compact record field decoder.
// Instantiates crfd_step and crfd_out_buf; depends on crfd_pkg.
//
// The decoder takes one stream byte per cycle and returns at most one result word
// per byte: the record count, a gathered integer, a string byte or an empty string,
// with field, struct and record completion flags. A byte sits in an input register
// until it is decoded against the field state while it sits there, and its result
// enters a two-entry output buffer. A result is offered once its byte has passed
// through the input register and then the output buffer, behind any older words. The
// sustained rate is one byte per clock; the input stalls only when the staged byte
// has a full output buffer ahead of it.
module compact_record_field_decoder import crfd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   stream_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          item_kind,
  output logic [VALUE_W-1:0]  item_value,
  output logic                field_done,
  output logic                struct_done,
  output logic                record_done
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_fire;
  logic              buf_full;
  crfd_state_t       state;
  crfd_state_t       state_next;
  logic              res_valid;
  crfd_result_t      res;
  crfd_result_t      out_data;

  assign in_stall = s1_valid && buf_full;
  assign s1_fire  = s1_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= stream_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= PH_COUNT;
      state.structs_left   <= '0;
      state.bytes_left     <= '0;
      state.gathered_value <= '0;
      state.int_length     <= '0;
      state.field_signed   <= 1'b0;
      state.field_is_last  <= 1'b0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  crfd_step u_step (
    .state       (state),
    .stream_byte (s1_byte),
    .state_next  (state_next),
    .res_valid   (res_valid),
    .res         (res)
  );

  crfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_fire && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign item_kind   = out_data.kind;
  assign item_value  = out_data.value;
  assign field_done  = out_data.field_done;
  assign struct_done = out_data.struct_done;
  assign record_done = out_data.record_done;

  a_struct_needs_field: assert property (@(posedge clk) disable iff (rst)
    (out_valid && struct_done) |-> field_done)
    else $error("struct_done without field_done");

  a_record_end_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_done) |-> (item_kind == KIND_COUNT || struct_done))
    else $error("record_done on a word that ends no struct and is no count");

  a_count_not_field: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == KIND_COUNT) |-> !field_done)
    else $error("count word marked as completing a field");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_byte))
    else $error("staged byte lost while input was stalled");

endmodule
